@@ hdl/sipq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted-insert priority queue package
// Shared types and constants for the sorted-insert priority queue: the
// request and response beats, one stored entry, the operation and status
// codes, and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package sipq_pkg;

	localparam int IdBits   = 16;
	localparam int PrioBits = 3;
	localparam int OccBits  = 8;

	localparam logic CmdEnq = 1'b0;
	localparam logic CmdDeq = 1'b1;

	localparam logic [1:0] StOk    = 2'd0;
	localparam logic [1:0] StFull  = 2'd1;
	localparam logic [1:0] StEmpty = 2'd2;

	typedef struct packed {
		logic                cmd;
		logic [IdBits-1:0]   item_id;
		logic [PrioBits-1:0] prio;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [IdBits-1:0]   head_id;
		logic [PrioBits-1:0] head_prio;
		logic [OccBits-1:0]  occupancy;
	} rsp_t;

	typedef struct packed {
		logic [IdBits-1:0]   id;
		logic [PrioBits-1:0] prio;
	} entry_t;

	typedef struct packed {
		logic load_req;
		logic init;
		logic shift;
		logic place;
		logic pop;
		logic fail;
		logic load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic is_enq;
		logic full;
		logic empty;
		logic lower;
		logic last;
	} dp_stat_t;

endpackage

@@ hdl/sipq_dp.sv @@
// ----------------------------------------------------------------------------
// Sorted-insert priority queue datapath
// Holds the entry memory as a circular buffer, the head pointer, the entry
// count, the insertion scan pointers and the response registers.
// ----------------------------------------------------------------------------
module sipq_dp #(
	parameter int DEPTH = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sipq_pkg::req_t      req,
	input  sipq_pkg::ctl_cmd_t  cmd,
	output sipq_pkg::dp_stat_t  stat,
	output sipq_pkg::rsp_t      rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int OB = sipq_pkg::OccBits;
	localparam logic [AW:0]   DepthA = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0] LastA  = AW'(DEPTH - 1);
	localparam logic [CW-1:0] DepthC = CW'(DEPTH);

	sipq_pkg::entry_t mem [DEPTH];

	sipq_pkg::req_t   req_q;
	sipq_pkg::entry_t rd_data_q;
	sipq_pkg::rsp_t   res_q;
	sipq_pkg::rsp_t   out_q;
	sipq_pkg::entry_t new_entry;
	sipq_pkg::entry_t wr_data;
	logic [AW-1:0]    head_q;
	logic [AW-1:0]    wr_q;
	logic [AW-1:0]    rd_q;
	logic [AW-1:0]    rd_next;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    pos_q;
	logic             wr_en;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] ofs);
		logic [AW:0] sum;
		sum = {1'b0, base} + (AW + 1)'(ofs);
		if (sum >= DepthA) begin
			sum = sum - DepthA;
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] dec(input logic [AW-1:0] p);
		return (p == '0) ? LastA : p - AW'(1);
	endfunction

	function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
		return (p == LastA) ? '0 : p + AW'(1);
	endfunction

	assign new_entry.id   = req_q.item_id;
	assign new_entry.prio = req_q.prio;

	assign stat.is_enq = (req_q.cmd == sipq_pkg::CmdEnq);
	assign stat.full   = (count_q == DepthC);
	assign stat.empty  = (count_q == '0);
	assign stat.lower  = (rd_data_q.prio < req_q.prio);
	assign stat.last   = (pos_q == CW'(1));

	always_comb begin
		priority if (cmd.init) begin
			rd_next = stat.is_enq ? phys(head_q, count_q - CW'(1)) : head_q;
		end else if (cmd.shift) begin
			rd_next = dec(rd_q);
		end else begin
			rd_next = rd_q;
		end
	end

	assign wr_en   = cmd.shift | cmd.place;
	assign wr_data = cmd.shift ? rd_data_q : new_entry;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_q] <= wr_data;
		end
		rd_data_q <= mem[rd_next];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			pos_q   <= '0;
		end else begin
			if (cmd.init) begin
				pos_q <= count_q;
			end else if (cmd.shift) begin
				pos_q <= pos_q - CW'(1);
			end
			if (cmd.place) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - CW'(1);
				head_q  <= inc(head_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= rd_next;
		if (cmd.load_req) begin
			req_q <= req;
		end
		if (cmd.init) begin
			wr_q <= phys(head_q, count_q);
		end else if (cmd.shift) begin
			wr_q <= rd_q;
		end
		if (cmd.fail) begin
			res_q.status    <= stat.is_enq ? sipq_pkg::StFull : sipq_pkg::StEmpty;
			res_q.head_id   <= '0;
			res_q.head_prio <= '0;
			res_q.occupancy <= OB'(count_q);
		end else if (cmd.place) begin
			res_q.status    <= sipq_pkg::StOk;
			res_q.head_id   <= '0;
			res_q.head_prio <= '0;
			res_q.occupancy <= OB'(count_q + CW'(1));
		end else if (cmd.pop) begin
			res_q.status    <= sipq_pkg::StOk;
			res_q.head_id   <= rd_data_q.id;
			res_q.head_prio <= rd_data_q.prio;
			res_q.occupancy <= OB'(count_q - CW'(1));
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	assign rsp = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DepthC)
		else $error("entry count exceeds depth");

	a_place_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.place |-> !stat.full)
		else $error("insert into a full queue");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !stat.empty)
		else $error("removal from an empty queue");

	a_shift_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> (pos_q != '0) && stat.is_enq)
		else $error("shift past the head of the queue");

endmodule

@@ hdl/sipq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sorted-insert priority queue controller
// Sequences one request at a time: capture, setup, tail-to-head scan with
// shifting, insertion or removal, and hand-off to the response register.
// ----------------------------------------------------------------------------
module sipq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	input  sipq_pkg::dp_stat_t  stat,
	output sipq_pkg::ctl_cmd_t  cmd
);

	localparam logic [2:0] SIdle  = 3'd0;
	localparam logic [2:0] SSetup = 3'd1;
	localparam logic [2:0] SScan  = 3'd2;
	localparam logic [2:0] SPlace = 3'd3;
	localparam logic [2:0] SDeq   = 3'd4;
	localparam logic [2:0] SDone  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign req_stall = (state_q != SIdle);
	assign rsp_valid = out_valid_q;
	assign slot_free = !out_valid_q || !rsp_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			SIdle: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = SSetup;
				end
			end
			SSetup: begin
				cmd.init = 1'b1;
				priority if (stat.is_enq && stat.full) begin
					cmd.fail = 1'b1;
					state_d  = SDone;
				end else if (!stat.is_enq && stat.empty) begin
					cmd.fail = 1'b1;
					state_d  = SDone;
				end else if (!stat.is_enq) begin
					state_d = SDeq;
				end else if (stat.empty) begin
					state_d = SPlace;
				end else begin
					state_d = SScan;
				end
			end
			SScan: begin
				if (stat.lower) begin
					cmd.shift = 1'b1;
					state_d   = stat.last ? SPlace : SScan;
				end else begin
					cmd.place = 1'b1;
					state_d   = SDone;
				end
			end
			SPlace: begin
				cmd.place = 1'b1;
				state_d   = SDone;
			end
			SDeq: begin
				cmd.pop = 1'b1;
				state_d = SDone;
			end
			SDone: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = SIdle;
				end
			end
			default: begin
				state_d = SIdle;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SIdle;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/sorted_insert_priority_queue.sv @@
// ----------------------------------------------------------------------------
// Sorted-insert priority queue
// A request beat on the req channel either enqueues item_id with prio or
// dequeues the head entry. Each request yields exactly one response beat on
// the rsp channel with a status, the removed entry on a successful dequeue,
// and the occupancy after the request. Higher priority is served first, and
// equal priorities leave in arrival order. The queue is full at DEPTH entries.
// Entries live in a single-port-write, registered-read memory used as a
// circular buffer, so a dequeue only advances the head pointer.
// One request is in flight at a time. A rejected request goes from setup
// straight to the response hand-off. A dequeue goes from setup to the
// removal and then to the hand-off; an enqueue that passes over k
// lower-priority entries shifts them one entry per cycle through the memory
// port, with k at most DEPTH - 1, before the insertion and the hand-off. The
// response is registered; a new request is accepted while a finished
// response still waits, and only the hand-off of the next response waits on
// rsp_stall. Reset empties the queue and drops any pending response; the
// memory itself is not cleared.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue #(
	parameter int DEPTH = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  sipq_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output sipq_pkg::rsp_t  rsp
);

	sipq_pkg::ctl_cmd_t cmd;
	sipq_pkg::dp_stat_t stat;

	sipq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	sipq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule
